[design/sap_pkg.sv]
// Shared types, constants and codes of the shelf atlas packer.
package sap_pkg;

  // Largest layer side in texels and largest number of layers in an atlas.
  localparam logic [12:0] MAX_SIDE = 13'd4096;
  localparam logic [11:0] MAX_LAYERS = 12'd2048;

  // Row start saturates here when a row wraps.
  localparam logic [12:0] ROW_SAT = 13'd8191;

  // Register reset values.
  localparam logic [12:0] RESET_LAYER_WIDTH = 13'd1024;
  localparam logic [12:0] RESET_LAYER_HEIGHT = 13'd1024;
  localparam logic [11:0] RESET_LAYER_COUNT = 12'd256;
  localparam logic [3:0] RESET_PADDING = 4'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LAYER_WIDTH = 2'd0;
  localparam logic [1:0] REG_LAYER_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LAYER_COUNT = 2'd2;
  localparam logic [1:0] REG_PADDING = 2'd3;

  // Operation codes.
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_CLEARED = 2'd3
  } sap_status_t;

  typedef struct packed {
    logic opcode;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } sap_in_t;

  typedef struct packed {
    sap_status_t status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [10:0] layer;
    logic [15:0] atlas_number;
    logic atlas_started;
  } sap_out_t;

  typedef struct packed {
    logic [12:0] layer_width;
    logic [12:0] layer_height;
    logic [11:0] layer_count;
    logic [3:0] padding;
  } sap_cfg_t;

  typedef struct packed {
    logic [12:0] cursor_col;
    logic [12:0] cursor_row;
    logic [12:0] row_height;
    logic [10:0] cur_layer;
    logic [15:0] atlas_seq;
    logic atlas_open;
  } sap_state_t;

endpackage

[design/sap_step.sv]
// Placement logic: next packing state and result for one item.
module sap_step
  import sap_pkg::*;
(
  input sap_cfg_t cfg,
  input sap_state_t state,
  input sap_in_t item,
  output sap_state_t state_next,
  output sap_out_t result
);

  logic [12:0] lw;
  logic [12:0] lh;
  logic [11:0] layers;
  logic open_first;
  logic [12:0] col0, row0, rh0;
  logic [11:0] li0;
  logic [15:0] seq0;
  logic wrap;
  logic [13:0] row_sum;
  logic [12:0] row_wrapped;
  logic [12:0] col1, row1, rh1;
  logic down;
  logic [11:0] li1;
  logic [12:0] col2, row2, rh2;
  logic reopen;
  logic [11:0] li2;
  logic [15:0] seq2;
  logic [12:0] rh_pad;

  // Effective layer size and layer count after clamping.
  always_comb begin
    lw = (cfg.layer_width > MAX_SIDE) ? MAX_SIDE : cfg.layer_width;
    lh = (cfg.layer_height > MAX_SIDE) ? MAX_SIDE : cfg.layer_height;
    if (cfg.layer_count == 12'd0) begin
      layers = 12'd1;
    end else if (cfg.layer_count > MAX_LAYERS) begin
      layers = MAX_LAYERS;
    end else begin
      layers = cfg.layer_count;
    end
  end

  // Shelf placement: open an atlas, wrap the row, move to the next layer,
  // and open a fresh atlas when the layers are used up.
  always_comb begin
    open_first = ~state.atlas_open;
    col0 = open_first ? 13'd0 : state.cursor_col;
    row0 = open_first ? 13'd0 : state.cursor_row;
    rh0 = open_first ? 13'd0 : state.row_height;
    li0 = open_first ? 12'd0 : {1'b0, state.cur_layer};
    seq0 = open_first ? state.atlas_seq + 16'd1 : state.atlas_seq;

    wrap = ({1'b0, col0} + {1'b0, item.rect_width}) > {1'b0, lw};
    row_sum = {1'b0, row0} + {1'b0, rh0};
    row_wrapped = (row_sum > {1'b0, ROW_SAT}) ? ROW_SAT : row_sum[12:0];
    col1 = wrap ? 13'd0 : col0;
    row1 = wrap ? row_wrapped : row0;
    rh1 = wrap ? 13'd0 : rh0;

    down = ({1'b0, row1} + {1'b0, item.rect_height}) > {1'b0, lh};
    li1 = down ? li0 + 12'd1 : li0;
    col2 = down ? 13'd0 : col1;
    row2 = down ? 13'd0 : row1;
    rh2 = down ? 13'd0 : rh1;

    reopen = (li1 >= layers);
    li2 = reopen ? 12'd0 : li1;
    seq2 = reopen ? seq0 + 16'd1 : seq0;
    if (reopen) begin
      col2 = 13'd0;
      row2 = 13'd0;
      rh2 = 13'd0;
    end

    rh_pad = item.rect_height + {9'd0, cfg.padding};
  end

  // Select the outcome of the item.
  always_comb begin
    state_next = state;
    result = '0;
    if (item.opcode == OP_CLEAR) begin
      state_next.cursor_col = 13'd0;
      state_next.cursor_row = 13'd0;
      state_next.row_height = 13'd0;
      state_next.cur_layer = 11'd0;
      state_next.atlas_open = 1'b0;
      result.status = STATUS_CLEARED;
    end else if (item.rect_width == 13'd0 || item.rect_height == 13'd0) begin
      result.status = STATUS_EMPTY;
    end else if (item.rect_width > lw || item.rect_height > lh) begin
      result.status = STATUS_TOO_LARGE;
    end else begin
      state_next.cursor_col = col2 + item.rect_width + {9'd0, cfg.padding};
      state_next.cursor_row = row2;
      state_next.row_height = (rh_pad > rh2) ? rh_pad : rh2;
      state_next.cur_layer = li2[10:0];
      state_next.atlas_seq = seq2;
      state_next.atlas_open = 1'b1;
      result.status = STATUS_PLACED;
      result.pos_x = col2[11:0];
      result.pos_y = row2[11:0];
      result.layer = li2[10:0];
      result.atlas_number = seq2;
      result.atlas_started = open_first | reopen;
    end
  end

endmodule

[design/shelf_atlas_packer.sv]
// Top level of the shelf atlas packer: registers, state and output skid stage.
// A result is registered at its item's transfer: in the result register, or in the skid entry while a result waits.
// Throughput: one item per cycle while in_stall is low; the packing state is updated in one pass.
// A two-entry output stage (result register plus skid) keeps the input open
// while one result waits. Reset clears the packing state, the output stage
// and loads the registers with their reset values; no clearing pass.
module shelf_atlas_packer
  import sap_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input sap_in_t in_item,
  output logic out_valid,
  input logic out_stall,
  output sap_out_t out_item,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [1:0] cfg_index,
  input logic [12:0] cfg_data
);

  sap_cfg_t cfg;
  sap_state_t state;
  sap_state_t state_next;
  sap_out_t result;
  sap_out_t skid_item;
  logic skid_valid;
  logic accept;
  logic out_take;

  assign cfg_ready = 1'b1;
  assign in_stall = skid_valid;
  assign accept = in_valid & ~skid_valid;
  assign out_take = out_valid & ~out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_width <= RESET_LAYER_WIDTH;
      cfg.layer_height <= RESET_LAYER_HEIGHT;
      cfg.layer_count <= RESET_LAYER_COUNT;
      cfg.padding <= RESET_PADDING;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYER_WIDTH: cfg.layer_width <= cfg_data;
        REG_LAYER_HEIGHT: cfg.layer_height <= cfg_data;
        REG_LAYER_COUNT: cfg.layer_count <= cfg_data[11:0];
        REG_PADDING: cfg.padding <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sap_step u_step (
    .cfg(cfg),
    .state(state),
    .item(in_item),
    .state_next(state_next),
    .result(result)
  );

  // Packing state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_item <= skid_item;
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_item <= result;
        end
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_item <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output is empty");

  // A waiting skid result moves up once the output transfer completes.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_take) |=> (out_valid && !skid_valid))
    else $error("skid result lost after output transfer");

  // With no atlas open the packing sits at layer zero.
  a_closed_layer_zero: assert property (@(posedge clk) disable iff (rst)
    !state.atlas_open |-> (state.cur_layer == 11'd0))
    else $error("layer index set while no atlas is open");

  // A clear closes the atlas.
  a_clear_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.opcode == OP_CLEAR) |=> !state.atlas_open)
    else $error("atlas still open after clear");

  // Only a placement can report a new atlas.
  a_started_placed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.atlas_started) |-> (out_item.status == STATUS_PLACED))
    else $error("atlas start flagged on a result that placed nothing");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the shelf atlas packer with its own placement predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sap_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sap_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sap_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  // Register copy used by the predictor and the rectangle generator.
  sap_cfg_t layout = '{RESET_LAYER_WIDTH, RESET_LAYER_HEIGHT, RESET_LAYER_COUNT,
                       RESET_PADDING};

  // Predicted packing state.
  int pk_col = 0;
  int pk_row = 0;
  int pk_rowh = 0;
  int pk_layer = 0;
  int pk_seq = 0;
  logic pk_open = 1'b0;

  sap_in_t rects_to_send[$];
  sap_out_t placements_due[$];
  sap_out_t due_result;

  int n_issued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  int cycle_count = 0;

  shelf_atlas_packer i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // A layer side register above the largest side acts as the largest side.
  function automatic int eff_side(logic [12:0] v);
    return (v > MAX_SIDE) ? int'(MAX_SIDE) : int'(v);
  endfunction

  function automatic void start_atlas();
    pk_seq = (pk_seq + 1) & 'hFFFF;
    pk_open = 1'b1;
    pk_layer = 0;
    pk_col = 0;
    pk_row = 0;
    pk_rowh = 0;
  endfunction

  // Works out the result of one item and moves the predicted state on.
  function automatic sap_out_t predict_placement(sap_in_t rect);
    sap_out_t res;
    int w, h, lw, lh, layers, wrapped_row;
    logic opened;
    res = '0;
    opened = 1'b0;
    w = rect.rect_width;
    h = rect.rect_height;
    lw = eff_side(layout.layer_width);
    lh = eff_side(layout.layer_height);
    layers = layout.layer_count;
    if (layers == 0) layers = 1;
    if (layers > MAX_LAYERS) layers = MAX_LAYERS;

    if (rect.opcode == OP_CLEAR) begin
      pk_col = 0;
      pk_row = 0;
      pk_rowh = 0;
      pk_layer = 0;
      pk_open = 1'b0;
      res.status = STATUS_CLEARED;
      return res;
    end
    if (w == 0 || h == 0) begin
      res.status = STATUS_EMPTY;
      return res;
    end
    if (w > lw || h > lh) begin
      res.status = STATUS_TOO_LARGE;
      return res;
    end

    if (!pk_open) begin
      start_atlas();
      opened = 1'b1;
    end
    // Wrap to a new row below the tallest rectangle of the current one.
    if (pk_col + w > lw) begin
      wrapped_row = pk_row + pk_rowh;
      pk_col = 0;
      pk_row = (wrapped_row > ROW_SAT) ? int'(ROW_SAT) : wrapped_row;
      pk_rowh = 0;
    end
    // Move to the next layer when the row runs off the bottom.
    if (pk_row + h > lh) begin
      pk_layer++;
      pk_col = 0;
      pk_row = 0;
      pk_rowh = 0;
    end
    if (pk_layer >= layers) begin
      start_atlas();
      opened = 1'b1;
    end

    res.status = STATUS_PLACED;
    res.pos_x = pk_col[11:0];
    res.pos_y = pk_row[11:0];
    res.layer = pk_layer[10:0];
    res.atlas_number = pk_seq[15:0];
    res.atlas_started = opened;

    pk_col = (pk_col + w + layout.padding) & 'h1FFF;
    if (h + layout.padding > pk_rowh) pk_rowh = (h + layout.padding) & 'h1FFF;
    return res;
  endfunction

  // Mostly rectangles that fit the current layer, with clears, empties and noise mixed in.
  function automatic sap_in_t random_rect();
    sap_in_t r;
    int lw, lh, pick, span;
    lw = eff_side(layout.layer_width);
    lh = eff_side(layout.layer_height);
    pick = $urandom_range(99);
    r.opcode = OP_PLACE;
    r.rect_width = 13'($urandom);
    r.rect_height = 13'($urandom);
    if (pick < 3) begin
      r.opcode = OP_CLEAR;
    end else if (pick < 8) begin
      if ($urandom_range(2) != 0) r.rect_width = '0;
      if ($urandom_range(1) != 0 || r.rect_width != 0) r.rect_height = '0;
    end else if (pick >= 15 && lw != 0 && lh != 0) begin
      span = lw >> $urandom_range(3);
      if (span < 1) span = 1;
      r.rect_width = 13'($urandom_range(span, 1));
      span = lh >> $urandom_range(4);
      if (span < 1) span = 1;
      r.rect_height = 13'($urandom_range(span, 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic queue_rect(sap_in_t r);
    rects_to_send.push_back(r);
    n_issued++;
  endtask

  // One register write transfer; the register copy follows at the handshake.
  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LAYER_WIDTH: layout.layer_width = value;
      REG_LAYER_HEIGHT: layout.layer_height = value;
      REG_LAYER_COUNT: layout.layer_count = value[11:0];
      REG_PADDING: layout.padding = value[3:0];
      default: ;
    endcase
  endtask

  // Every item gives one result, so the block is idle once all have come back.
  task automatic settle();
    while (results_seen < n_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(logic [12:0] lw, logic [12:0] lh, logic [12:0] cnt,
                           logic [12:0] pad, int n_rects, int send_pct, int recv_pct);
    settle();
    write_reg(REG_LAYER_WIDTH, lw);
    write_reg(REG_LAYER_HEIGHT, lh);
    write_reg(REG_LAYER_COUNT, cnt);
    write_reg(REG_PADDING, pad);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_rects) queue_rect(random_rect());
  endtask

  // Sender: predicts each item at its transfer, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        placements_due.push_back(predict_placement(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (rects_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= rects_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall.
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: each result transfer is checked against the oldest placement due.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (placements_due.size() == 0) begin
        report_mismatch("result transfer with no placement due");
      end else begin
        due_result = placements_due.pop_front();
        if (out_item.status !== due_result.status)
          report_mismatch($sformatf("status got %0d, expected %0d",
                                    out_item.status, due_result.status));
        if (out_item.pos_x !== due_result.pos_x)
          report_mismatch($sformatf("pos_x got %0d, expected %0d",
                                    out_item.pos_x, due_result.pos_x));
        if (out_item.pos_y !== due_result.pos_y)
          report_mismatch($sformatf("pos_y got %0d, expected %0d",
                                    out_item.pos_y, due_result.pos_y));
        if (out_item.layer !== due_result.layer)
          report_mismatch($sformatf("layer got %0d, expected %0d",
                                    out_item.layer, due_result.layer));
        if (out_item.atlas_number !== due_result.atlas_number)
          report_mismatch($sformatf("atlas_number got %0d, expected %0d",
                                    out_item.atlas_number, due_result.atlas_number));
        if (out_item.atlas_started !== due_result.atlas_started)
          report_mismatch($sformatf("atlas_started got %0d, expected %0d",
                                    out_item.atlas_started, due_result.atlas_started));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 87;

    // Directed items at the reset register values.
    queue_rect(sap_in_t'{OP_PLACE, 13'd0, 13'd0});
    queue_rect(sap_in_t'{OP_PLACE, 13'd0, 13'd7});
    queue_rect(sap_in_t'{OP_PLACE, 13'd9, 13'd0});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1024, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1025, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1, 13'd1025});
    queue_rect(sap_in_t'{OP_PLACE, 13'h1FFF, 13'h1FFF});
    queue_rect(sap_in_t'{OP_PLACE, 13'd4096, 13'd4096});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1024, 13'd1024});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1000, 13'd500});
    queue_rect(sap_in_t'{OP_PLACE, 13'd20, 13'd500});
    queue_rect(sap_in_t'{OP_PLACE, 13'd3, 13'd600});
    queue_rect(sap_in_t'{OP_CLEAR, 13'h1FFF, 13'h1FFF});
    queue_rect(sap_in_t'{OP_CLEAR, 13'd0, 13'd0});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd1023, 13'd1023});
    queue_rect(sap_in_t'{OP_PLACE, 13'd512, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd512, 13'd1});
    queue_rect(sap_in_t'{OP_PLACE, 13'd2048, 13'd1});
    queue_rect(sap_in_t'{OP_CLEAR, 13'd5, 13'd5});
    queue_rect(sap_in_t'{OP_PLACE, 13'h0AAA, 13'h1555});
    repeat (150) queue_rect(random_rect());

    // Register settings change without a clear, so packing carries over.
    run_phase(13'd64, 13'd48, 13'd3, 13'd1, 350, 23, 87);
    run_phase(13'd1, 13'd1, 13'd1, 13'd0, 150, 23, 87);
    run_phase(13'd4096, 13'd4096, 13'd2048, 13'd15, 250, 87, 23);
    run_phase(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 150, 87, 23);
    run_phase(13'd0, 13'd0, 13'd0, 13'd0, 60, 87, 23);
    run_phase(13'd37, 13'd29, 13'd2, 13'd7, 300, 0, 0);
    // Hold the receiver off while the sender keeps offering, to fill the block.
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    run_phase(13'd300, 13'd200, 13'd5, 13'd3, 450, 0, 0);

    settle();
    if (placements_due.size() != 0)
      report_mismatch($sformatf("%0d placements never arrived", placements_due.size()));
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sap_pkg.sv
design/sap_step.sv
design/shelf_atlas_packer.sv
tb/tb.sv
